// ----- rtl/core/bia_pkg.sv -----
// shared types and constants of the bus interface arbiter
package bia_pkg;

	typedef enum logic [1:0] {
		KIND_REQUEST    = 2'd0,
		KIND_COMPLETION = 2'd1,
		KIND_TICK       = 2'd2,
		KIND_NONE       = 2'd3
	} kind_t;

	localparam logic [1:0] REQ_SLAVE = 2'd0;
	localparam logic [1:0] REQ_BIU   = 2'd1;
	localparam logic [1:0] REQ_DMA   = 2'd2;
	localparam logic [1:0] NO_OWNER  = 2'd3;

	localparam logic [1:0] CFG_W0_BASE  = 2'd0;
	localparam logic [1:0] CFG_W0_LIMIT = 2'd1;
	localparam logic [1:0] CFG_W1_BASE  = 2'd2;
	localparam logic [1:0] CFG_W1_LIMIT = 2'd3;

	localparam logic [31:0] W0_BASE_RST  = 32'h0020_0000;
	localparam logic [31:0] W0_LIMIT_RST = 32'h002f_ffff;
	localparam logic [31:0] W1_BASE_RST  = 32'h0060_0000;
	localparam logic [31:0] W1_LIMIT_RST = 32'h006f_ffff;

	localparam logic [15:0] LAT_MAX = 16'hffff;

	typedef struct packed {
		logic [31:0] addr;
		logic [1:0]  req;
		logic        rd;
		logic        tgt;
	} entry_t;

	// classified item handed from front to back
	typedef struct packed {
		kind_t       kind;
		entry_t      ent;
		logic [15:0] lat;
		logic        ok;
		logic        locked;
	} cmd_t;

	typedef struct packed {
		logic        tgt;
		logic        granted;
		logic        held;
		logic        route_busy;
		logic        queue_full;
		logic [15:0] charged;
		logic        busy_left;
		logic [15:0] busy_cycles;
	} result_t;

endpackage

// ----- rtl/core/bia_front.sv -----
// front end: window decode, requester clamp and command fifo
module bia_front import bia_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  in_kind,
	input  logic [1:0]  in_req,
	input  logic [31:0] in_addr,
	input  logic        in_rd,
	input  logic [15:0] in_lat,
	input  logic        in_ok,
	input  logic        in_locked,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);

	logic [31:0] w0b_q, w0l_q, w1b_q, w1l_q;
	cmd_t        fifo_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	cmd_t        c;
	logic        push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0b_q <= W0_BASE_RST;
			w0l_q <= W0_LIMIT_RST;
			w1b_q <= W1_BASE_RST;
			w1l_q <= W1_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_W0_BASE:  w0b_q <= cfg_data;
				CFG_W0_LIMIT: w0l_q <= cfg_data;
				CFG_W1_BASE:  w1b_q <= cfg_data;
				CFG_W1_LIMIT: w1l_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		c.kind       = kind_t'(in_kind);
		c.ent.addr   = in_addr;
		c.ent.req    = (in_req == NO_OWNER) ? REQ_DMA : in_req;
		c.ent.rd     = in_rd;
		c.ent.tgt    = (in_addr >= w0b_q && in_addr <= w0l_q) ||
		               (in_addr >= w1b_q && in_addr <= w1l_q);
		c.lat        = in_lat;
		c.ok         = in_ok;
		c.locked     = in_locked;
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ----- rtl/core/bia_back.sv -----
// back end: sorted request queue, lock, latency and busy counters
module bia_back import bia_pkg::*; #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	output logic    cmd_ready,
	input  cmd_t    cmd,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

	state_t       state_q;
	cmd_t         cmd_q;
	entry_t       q_q [QUEUE_DEPTH];
	logic [CW-1:0] count_q;
	entry_t       held_q;
	logic         hold_q;
	logic         prev_none_q;
	logic [15:0]  prev_q;
	logic [15:0]  burst_q;
	logic [1:0]   lock_q;
	logic [15:0]  rbusy_q [3];
	logic [15:0]  tbusy_q [2];
	logic         out_valid_q;
	result_t      out_q;

	// combinational helpers over the queue (independent per entry)
	entry_t       r;
	logic [QUEUE_DEPTH-1:0] live, dup, outr, tmatch, sameq;
	logic         found_dup, grant;
	logic [CW-1:0] pos;
	logic         insert_ok;
	logic [15:0]  bmax;
	logic [16:0]  t_add, burst_sum;
	logic [15:0]  t_sat, burst_sat;
	logic         still;
	result_t      res_d;

	always_comb begin
		r = (cmd_q.kind == KIND_TICK) ? held_q : cmd_q.ent;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			live[i]   = (CW'(i) < count_q);
			sameq[i]  = live[i] && (q_q[i] == r);
			tmatch[i] = live[i] && (q_q[i].tgt == r.tgt);
			outr[i]   = live[i] && ((r.tgt != q_q[i].tgt) ? (r.tgt < q_q[i].tgt)
			                                             : (r.req < q_q[i].req));
		end
		// first of dup or outranks decides
		found_dup = 1'b0;
		pos = count_q;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (sameq[i] || outr[i]) begin
				found_dup = sameq[i];
				pos = CW'(i);
			end
		end
		dup = sameq;
		// grant over the queue before any change
		grant = 1'b0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (tmatch[i]) grant = dup[i];
		end
		insert_ok = (count_q < CW'(QUEUE_DEPTH));
		bmax = 16'd1;
		for (int i = 0; i < 3; i++) if (rbusy_q[i] > bmax) bmax = rbusy_q[i];
		for (int i = 0; i < 2; i++) if (tbusy_q[i] > bmax) bmax = tbusy_q[i];
		t_add = prev_none_q ? ((cmd_q.ent.req == REQ_BIU && cmd_q.ent.tgt) ? 17'd0 : 17'd1)
		                    : 17'd1;
		if ((prev_none_q ? 16'd0 : prev_q) < cmd_q.lat)
			t_add = t_add + {1'b0, cmd_q.lat - (prev_none_q ? 16'd0 : prev_q)};
		t_sat = t_add[16] ? LAT_MAX : t_add[15:0];
		burst_sum = {1'b0, burst_q} + {1'b0, t_sat};
		burst_sat = burst_sum[16] ? LAT_MAX : burst_sum[15:0];
		still = 1'b0;
		for (int i = 0; i < 3; i++) if (rbusy_q[i] > 16'd1) still = 1'b1;
		for (int i = 0; i < 2; i++) if (tbusy_q[i] > 16'd1) still = 1'b1;
		res_d = '0;
		case (cmd_q.kind)
			KIND_REQUEST: begin
				res_d.tgt        = cmd_q.ent.tgt;
				res_d.route_busy = (rbusy_q[cmd_q.ent.req] != 16'd0) ||
				                   (tbusy_q[cmd_q.ent.tgt] != 16'd0);
				if (found_dup) res_d.granted = (lock_q == r.req) || grant;
				else if (cmd_q.ent.req == REQ_SLAVE) res_d.held = 1'b1;
				else begin
					res_d.queue_full = !insert_ok;
					res_d.granted = (lock_q == r.req) ||
					    (insert_ok && !(|(tmatch & ~outr & ((QUEUE_DEPTH)'(1) << pos) - 1'b1)))
					    || (!insert_ok && grant);
				end
			end
			KIND_COMPLETION: begin
				res_d.tgt     = cmd_q.ent.tgt;
				res_d.charged = t_sat;
			end
			KIND_TICK: begin
				res_d.queue_full = hold_q && !found_dup && !insert_ok;
				res_d.busy_left  = still;
			end
			default: ;
		endcase
	end

	assign cmd_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid && cmd_ready) cmd_q <= cmd;
		if (state_q == ST_SCAN) begin
			case (cmd_q.kind)
				KIND_REQUEST: begin
					if (!found_dup && cmd_q.ent.req == REQ_SLAVE) held_q <= cmd_q.ent;
					else if (!found_dup && insert_ok) begin
						for (int i = 0; i < QUEUE_DEPTH; i++) begin
							if (CW'(i) == pos) q_q[i] <= r;
							else if (CW'(i) > pos && i > 0) q_q[i] <= q_q[i-1];
						end
					end
				end
				KIND_TICK: begin
					if (hold_q && !found_dup && insert_ok) begin
						for (int i = 0; i < QUEUE_DEPTH; i++) begin
							if (CW'(i) == pos) q_q[i] <= r;
							else if (CW'(i) > pos && i > 0) q_q[i] <= q_q[i-1];
						end
					end
				end
				KIND_COMPLETION: begin
					// entries are unique, so at most one match is removed
					for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
						if ((sameq & (((QUEUE_DEPTH)'(1) << (i + 1)) - 1'b1)) != '0)
							q_q[i] <= q_q[i+1];
					end
				end
				default: ;
			endcase
		end
		if (state_q == ST_SCAN) out_q <= res_d;
		if (state_q == ST_DONE) out_q.busy_cycles <= bmax;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			hold_q      <= 1'b0;
			prev_none_q <= 1'b1;
			prev_q      <= '0;
			burst_q     <= '0;
			lock_q      <= NO_OWNER;
			for (int i = 0; i < 3; i++) rbusy_q[i] <= '0;
			for (int i = 0; i < 2; i++) tbusy_q[i] <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && res_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (cmd_valid && cmd_ready) state_q <= ST_SCAN;
				ST_SCAN: begin
					state_q <= ST_DONE;
					case (cmd_q.kind)
						KIND_REQUEST: begin
							if (!found_dup && cmd_q.ent.req == REQ_SLAVE) hold_q <= 1'b1;
							else if (!found_dup && insert_ok) count_q <= count_q + 1'b1;
						end
						KIND_TICK: begin
							hold_q <= 1'b0;
							if (hold_q && !found_dup && insert_ok) count_q <= count_q + 1'b1;
							for (int i = 0; i < 3; i++)
								if (rbusy_q[i] != 16'd0) rbusy_q[i] <= rbusy_q[i] - 16'd1;
							for (int i = 0; i < 2; i++)
								if (tbusy_q[i] != 16'd0) tbusy_q[i] <= tbusy_q[i] - 16'd1;
						end
						KIND_COMPLETION: begin
							if (|sameq) count_q <= count_q - 1'b1;
							if (!cmd_q.locked && cmd_q.ok) begin
								rbusy_q[cmd_q.ent.req] <= burst_sat;
								tbusy_q[cmd_q.ent.tgt] <= burst_sat;
								prev_none_q <= 1'b1;
								burst_q     <= '0;
								lock_q      <= NO_OWNER;
							end else begin
								prev_none_q <= 1'b0;
								prev_q      <= cmd_q.lat;
								burst_q     <= burst_sat;
								lock_q      <= cmd_q.ent.req;
							end
						end
						default: ;
					endcase
				end
				ST_DONE: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/bus_interface_arbiter.sv -----
// top level of the bus interface arbiter
// Usage:
//  s_axis carries one transaction per item: a request, a completion or a tick.
//  tuser holds the kind; tdata holds the remaining fields.
//  m_axis returns exactly one result transaction per accepted item.
//  cfg writes the four local window registers; the user must write them only
//  while the block is idle, and the block itself does not enforce this.
// From acceptance an item passes the front fifo, is loaded into the back
//  end command register, is scanned with the queue updated, and has its busy
//  maximum written into the output register before the result is valid.
// The back end sequencer (load, scan, finish) waits for the result
//  transaction to complete before it takes the next item.
// The front fifo of two entries keeps accepting while the back end works.
// Reset clears the queue count, hold, lock and busy counters at once;
// queue entries themselves are not cleared.
// When m_axis_tready is low the result is held and the back end stalls;
// the front fifo then fills and s_axis_tready drops.
module bus_interface_arbiter import bia_pkg::*; #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// requester, address, is_read, target_latency, target_ok, requester_locked
	input  logic [55:0] s_axis_tdata,
	// kind
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// target, granted, held, route_busy, queue_full, charged_latency,
	// busy_left, busy_cycles
	output logic [39:0] m_axis_tdata
);

	logic    cmd_valid, cmd_ready;
	cmd_t    cmd;
	result_t res;

	bia_front u_front (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.in_req    (s_axis_tdata[1:0]),
		.in_addr   (s_axis_tdata[33:2]),
		.in_rd     (s_axis_tdata[34]),
		.in_lat    (s_axis_tdata[50:35]),
		.in_ok     (s_axis_tdata[51]),
		.in_locked (s_axis_tdata[52]),
		.cmd_valid, .cmd_ready, .cmd
	);

	bia_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res
	);

	assign m_axis_tdata = {2'b00, res.busy_cycles, res.busy_left, res.charged,
		res.queue_full, res.route_busy, res.held, res.granted, res.tgt};

	a_busy_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[37:22] != 16'd0)
		else $error("busy_cycles zero");
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[2]))
		else $error("granted and held together");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped");

endmodule
